FILE: design/gcr_track_formatter_macros.svh
// Assertion macros shared by the track formatter RTL.
// Included by the top level only; needs no package.
`ifndef GCR_TRACK_FORMATTER_MACROS_SVH
`define GCR_TRACK_FORMATTER_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define GTF_ASSERT_IMP(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("gcr_track_formatter: implication check failed");

// Next-cycle implication, checked only out of reset.
`define GTF_ASSERT_NXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("gcr_track_formatter: next-cycle check failed");

`endif

FILE: design/gtf_pkg.sv
// Shared types, constants and GCR coding functions of the track formatter.
// Used by every module of the block but gtf_fifo; depends on nothing.
package gtf_pkg;

    localparam int HEADER_GAP_DEF  = 9;
    localparam int SYNC_LENGTH_DEF = 5;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Wide enough for the largest run: the inter-sector gap of up to 40 bytes.
    localparam int CNT_W   = 6;
    localparam int PADDR_W = 5;
    localparam int IDX_W   = 3;

    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] GAP_BYTE    = 8'h55;
    localparam logic [7:0] DATA_MARK   = 8'h07;
    localparam logic [7:0] HEADER_MARK = 8'h08;
    localparam logic [7:0] ID_PAD      = 8'h0F;
    localparam logic [5:0] GAP_LIMIT   = 6'd40;

    localparam logic [IDX_W-1:0] REG_TRACK   = 3'd0;
    localparam logic [IDX_W-1:0] REG_ID_1ST  = 3'd1;
    localparam logic [IDX_W-1:0] REG_ID_2ND  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SECTORS = 3'd3;
    localparam logic [IDX_W-1:0] REG_GAP     = 3'd4;

    localparam logic [5:0] TRACK_RST   = 6'd1;
    localparam logic [7:0] ID_RST      = 8'd0;
    localparam logic [4:0] SECTORS_RST = 5'd21;
    localparam logic [5:0] GAP_RST     = 6'd8;

    typedef struct packed {
        logic [5:0] track_number;
        logic [7:0] disk_id_first;
        logic [7:0] disk_id_second;
        logic [4:0] sectors_per_track;
        logic [5:0] gap_count;
    } cfg_t;

    // One unit of work for the back end: either a whole sector preamble
    // (sync, two header groups, header gap, sync) or one data group
    // optionally followed by the inter-sector gap.
    typedef struct packed {
        logic        is_hdr;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [5:0]  gap;
        logic        ends_track;
    } cmd_t;

    function automatic logic [4:0] gcr_nibble(input logic [3:0] nib);
        logic [4:0] code;
        case (nib)
            4'h0: code = 5'h0A;
            4'h1: code = 5'h0B;
            4'h2: code = 5'h12;
            4'h3: code = 5'h13;
            4'h4: code = 5'h0E;
            4'h5: code = 5'h0F;
            4'h6: code = 5'h16;
            4'h7: code = 5'h17;
            4'h8: code = 5'h09;
            4'h9: code = 5'h19;
            4'hA: code = 5'h1A;
            4'hB: code = 5'h1B;
            4'hC: code = 5'h0D;
            4'hD: code = 5'h1D;
            4'hE: code = 5'h1E;
            4'hF: code = 5'h15;
            default: code = 5'h0A;
        endcase
        return code;
    endfunction

    // Four bytes, first byte in the top bits, become five GCR bytes.
    function automatic logic [39:0] gcr_encode(input logic [31:0] word);
        logic [39:0] bits;
        bits = '0;
        for (int i = 0; i < 8; i++) begin
            bits[39-5*i -: 5] = gcr_nibble(word[31-4*i -: 4]);
        end
        return bits;
    endfunction

endpackage

FILE: design/gtf_front.sv
// Front end: accepts data bytes, tracks sector position and checksums, and
// turns each byte that causes output into a command. Depends on gtf_pkg.
module gtf_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_data_byte,
    input  gtf_pkg::cfg_t   cfg,
    input  logic            q_full,
    output logic            push,
    output gtf_pkg::cmd_t   cmd
);

    logic [7:0]  pos_reg, pos_next;
    logic [4:0]  sector_reg, sector_next;
    logic [23:0] group_reg, group_next;
    logic [7:0]  chk_reg, chk_next;

    logic        accept;
    logic        first_byte;
    logic        final_byte;
    logic [23:0] grp_in;
    logic [7:0]  chk_in;
    logic [7:0]  hdr_chk;
    logic [5:0]  sector_inc;
    logic        last_sec;
    logic [5:0]  gap_sat;
    logic [31:0] word;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        first_byte = (pos_reg == 8'd0);
        final_byte = (pos_reg == 8'd255);
        grp_in     = first_byte ? {16'h0000, gtf_pkg::DATA_MARK} : group_reg;
        chk_in     = first_byte ? 8'h00 : chk_reg;
        hdr_chk    = {3'b000, sector_reg} ^ {2'b00, cfg.track_number}
                     ^ cfg.disk_id_first ^ cfg.disk_id_second;
        sector_inc = {1'b0, sector_reg} + 6'd1;
        last_sec   = (sector_inc >= {1'b0, cfg.sectors_per_track});
        gap_sat    = (cfg.gap_count > gtf_pkg::GAP_LIMIT) ? gtf_pkg::GAP_LIMIT : cfg.gap_count;
        word       = {grp_in, s_data_byte};

        pos_next    = pos_reg;
        sector_next = sector_reg;
        group_next  = group_reg;
        chk_next    = chk_reg;
        push        = 1'b0;
        cmd         = '0;

        if (accept) begin
            if (first_byte) begin
                cmd.is_hdr = 1'b1;
                cmd.word_a = {gtf_pkg::HEADER_MARK, hdr_chk, 3'b000, sector_reg,
                              2'b00, cfg.track_number};
                cmd.word_b = {cfg.disk_id_second, cfg.disk_id_first,
                              gtf_pkg::ID_PAD, gtf_pkg::ID_PAD};
                push       = 1'b1;
            end
            if (final_byte) begin
                cmd.word_a     = {s_data_byte, chk_in ^ s_data_byte, 16'h0000};
                cmd.gap        = gap_sat;
                cmd.ends_track = last_sec;
                push           = 1'b1;
                sector_next    = last_sec ? 5'd0 : sector_inc[4:0];
                group_next     = '0;
                chk_next       = '0;
                pos_next       = 8'd0;
            end else begin
                chk_next = chk_in ^ s_data_byte;
                if (pos_reg[1:0] == 2'd2) begin
                    cmd.word_a = word;
                    push       = 1'b1;
                    group_next = '0;
                end else begin
                    group_next = word[23:0];
                end
                pos_next = pos_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            sector_reg <= '0;
            group_reg  <= '0;
            chk_reg    <= '0;
        end else begin
            pos_reg    <= pos_next;
            sector_reg <= sector_next;
            group_reg  <= group_next;
            chk_reg    <= chk_next;
        end
    end

endmodule

FILE: design/gtf_fifo.sv
// Short command queue between the front and back ends of the formatter.
// Generic over width and depth; depends on nothing.
module gtf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/gtf_back.sv
// Back end: walks the command at the head of the queue and emits one track
// byte per cycle into the output register unless stalled. Depends on gtf_pkg.
module gtf_back #(
    parameter int HEADER_GAP  = gtf_pkg::HEADER_GAP_DEF,
    parameter int SYNC_LENGTH = gtf_pkg::SYNC_LENGTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  gtf_pkg::cmd_t head,
    input  logic          q_empty,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_gcr_byte,
    output logic          m_last_of_run,
    output logic          m_track_done
);

    localparam int CW = gtf_pkg::CNT_W;

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_SYNC1 = 3'd1;
    localparam logic [2:0] PH_HDR_A = 3'd2;
    localparam logic [2:0] PH_HDR_B = 3'd3;
    localparam logic [2:0] PH_HGAP  = 3'd4;
    localparam logic [2:0] PH_SYNC2 = 3'd5;
    localparam logic [2:0] PH_GRP   = 3'd6;
    localparam logic [2:0] PH_GAP   = 3'd7;

    logic [2:0]    phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_byte_reg, m_byte_next;
    logic          m_last_reg, m_last_next;
    logic          m_done_reg, m_done_next;

    logic          advance;
    logic [2:0]    phase_eff;
    logic [2:0]    phase_after;
    logic [39:0]   enc;
    logic [7:0]    grp_byte;
    logic [7:0]    out_byte;
    logic          run_last;
    logic          end_cmd;

    assign m_valid       = m_valid_reg;
    assign m_gcr_byte    = m_byte_reg;
    assign m_last_of_run = m_last_reg;
    assign m_track_done  = m_done_reg;

    always_comb begin
        advance   = !q_empty && (!m_valid_reg || m_ready);
        phase_eff = (phase_reg == PH_START) ? (head.is_hdr ? PH_SYNC1 : PH_GRP) : phase_reg;
        enc       = gtf_pkg::gcr_encode((phase_eff == PH_HDR_B) ? head.word_b : head.word_a);

        case (cnt_reg[2:0])
            3'd0:    grp_byte = enc[39:32];
            3'd1:    grp_byte = enc[31:24];
            3'd2:    grp_byte = enc[23:16];
            3'd3:    grp_byte = enc[15:8];
            3'd4:    grp_byte = enc[7:0];
            default: grp_byte = enc[7:0];
        endcase

        out_byte    = gtf_pkg::SYNC_BYTE;
        run_last    = 1'b0;
        end_cmd     = 1'b0;
        phase_after = PH_START;
        case (phase_eff)
            PH_SYNC1: begin
                run_last    = (cnt_reg == CW'(SYNC_LENGTH - 1));
                phase_after = PH_HDR_A;
            end
            PH_HDR_A: begin
                out_byte    = grp_byte;
                run_last    = (cnt_reg == CW'(4));
                phase_after = PH_HDR_B;
            end
            PH_HDR_B: begin
                out_byte    = grp_byte;
                run_last    = (cnt_reg == CW'(4));
                phase_after = PH_HGAP;
            end
            PH_HGAP: begin
                out_byte    = gtf_pkg::GAP_BYTE;
                run_last    = (cnt_reg == CW'(HEADER_GAP - 1));
                phase_after = PH_SYNC2;
            end
            PH_SYNC2: begin
                run_last = (cnt_reg == CW'(SYNC_LENGTH - 1));
                end_cmd  = run_last;
            end
            PH_GRP: begin
                out_byte    = grp_byte;
                run_last    = (cnt_reg == CW'(4));
                end_cmd     = run_last && (head.gap == '0);
                phase_after = PH_GAP;
            end
            PH_GAP: begin
                out_byte = gtf_pkg::GAP_BYTE;
                run_last = (cnt_reg == CW'(head.gap - 6'd1));
                end_cmd  = run_last;
            end
            default: begin
                out_byte = gtf_pkg::SYNC_BYTE;
            end
        endcase

        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_done_next  = m_done_reg;
        pop          = 1'b0;

        if (advance) begin
            m_valid_next = 1'b1;
            m_byte_next  = out_byte;
            m_last_next  = end_cmd;
            m_done_next  = end_cmd && head.ends_track;
            pop          = end_cmd;
            if (end_cmd) begin
                phase_next = PH_START;
                cnt_next   = '0;
            end else if (run_last) begin
                phase_next = phase_after;
                cnt_next   = '0;
            end else begin
                phase_next = phase_eff;
                cnt_next   = cnt_reg + 1'b1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_done_reg <= m_done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: design/gcr_track_formatter.sv
// Top level of the GCR track formatter: APB registers, front end, command
// queue and back end. Depends on gtf_pkg, gtf_front, gtf_fifo, gtf_back and the macros header.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_data_byte
//   m_        out        m_valid/m_ready    m_gcr_byte, m_last_of_run, m_track_done
//   APB       in         psel/penable       paddr, pwdata, prdata
//
// The back end emits one track byte per cycle from the command queue while the
// output is not stalled; that byte stream sets the pace. Data bytes are
// taken every cycle while the queue has room. Reset is synchronous, active low,
// and needs no clearing pass. A stalled output holds the back end, and the
// front end as well once the queue has filled.
`include "gcr_track_formatter_macros.svh"

module gcr_track_formatter #(
    parameter int HEADER_GAP  = gtf_pkg::HEADER_GAP_DEF,
    parameter int SYNC_LENGTH = gtf_pkg::SYNC_LENGTH_DEF,
    parameter int QUEUE_DEPTH = gtf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_data_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_gcr_byte,
    output logic                        m_last_of_run,
    output logic                        m_track_done,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gtf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int CMD_W = $bits(gtf_pkg::cmd_t);
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

    gtf_pkg::cfg_t               cfg_reg, cfg_next;
    logic                        cfg_wr;
    logic [gtf_pkg::IDX_W-1:0]   reg_idx;

    logic                        push;
    logic                        pop;
    gtf_pkg::cmd_t               cmd_in;
    gtf_pkg::cmd_t               cmd_head;
    logic [CMD_W-1:0]            head_bits;
    logic                        q_empty;
    logic                        q_full;
    logic [QC_W-1:0]             q_count;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[gtf_pkg::PADDR_W-1:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                gtf_pkg::REG_TRACK:   cfg_next.track_number      = pwdata[5:0];
                gtf_pkg::REG_ID_1ST:  cfg_next.disk_id_first     = pwdata[7:0];
                gtf_pkg::REG_ID_2ND:  cfg_next.disk_id_second    = pwdata[7:0];
                gtf_pkg::REG_SECTORS: cfg_next.sectors_per_track = pwdata[4:0];
                gtf_pkg::REG_GAP:     cfg_next.gap_count         = pwdata[5:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            gtf_pkg::REG_TRACK:   prdata = {26'd0, cfg_reg.track_number};
            gtf_pkg::REG_ID_1ST:  prdata = {24'd0, cfg_reg.disk_id_first};
            gtf_pkg::REG_ID_2ND:  prdata = {24'd0, cfg_reg.disk_id_second};
            gtf_pkg::REG_SECTORS: prdata = {27'd0, cfg_reg.sectors_per_track};
            gtf_pkg::REG_GAP:     prdata = {26'd0, cfg_reg.gap_count};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.track_number      <= gtf_pkg::TRACK_RST;
            cfg_reg.disk_id_first     <= gtf_pkg::ID_RST;
            cfg_reg.disk_id_second    <= gtf_pkg::ID_RST;
            cfg_reg.sectors_per_track <= gtf_pkg::SECTORS_RST;
            cfg_reg.gap_count         <= gtf_pkg::GAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    gtf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .push        (push),
        .cmd         (cmd_in)
    );

    gtf_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   (cmd_in),
        .pop     (pop),
        .rdata   (head_bits),
        .empty   (q_empty),
        .full    (q_full),
        .count   (q_count)
    );

    assign cmd_head = gtf_pkg::cmd_t'(head_bits);

    gtf_back #(
        .HEADER_GAP  (HEADER_GAP),
        .SYNC_LENGTH (SYNC_LENGTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (cmd_head),
        .q_empty       (q_empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_gcr_byte    (m_gcr_byte),
        .m_last_of_run (m_last_of_run),
        .m_track_done  (m_track_done)
    );

    // The end of a track is always the end of a command.
    `GTF_ASSERT_IMP(a_done_is_last, aclk, aresetn, m_valid && m_track_done, m_last_of_run)
    // Pending work with a free output register always yields a byte next cycle.
    `GTF_ASSERT_NXT(a_back_progress, aclk, aresetn,
                    (q_count != '0) && (!m_valid || m_ready), m_valid)
    // A command's bytes follow one another without a bubble.
    `GTF_ASSERT_NXT(a_run_unbroken, aclk, aresetn,
                    m_valid && m_ready && !m_last_of_run, m_valid)

endmodule

FILE: sim/gcr_track_formatter_chk.sv
`timescale 1ns / 100ps
// Scoreboard of the GCR track formatter: follows register writes, predicts the coded
// track bytes of every accepted data byte and compares the result stream.
// Depends on gtf_pkg for constants and register indexes.
module gcr_track_formatter_chk
    import gtf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [7:0]         m_gcr_byte,
    input  logic               m_last_of_run,
    input  logic               m_track_done,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 error_count,
    output int                 pending_count,
    output int                 bytes_checked,
    output int                 tracks_closed
);

    typedef struct packed {
        logic [7:0] code;
        logic       run_end;
        logic       track_end;
    } track_byte_t;

    // Five-bit GCR code of each nibble, nibble 0 in the low bits.
    localparam logic [79:0] NIB_GCR = {
        5'h15, 5'h1E, 5'h1D, 5'h0D, 5'h1B, 5'h1A, 5'h19, 5'h09,
        5'h17, 5'h16, 5'h0F, 5'h0E, 5'h13, 5'h12, 5'h0B, 5'h0A
    };

    track_byte_t track_q[$];

    logic [5:0] trk_num;
    logic [7:0] id_a;
    logic [7:0] id_b;
    logic [4:0] sec_total;
    logic [5:0] gap_len;

    logic [7:0]  byte_pos;
    logic [4:0]  sector;
    logic [23:0] held_bytes;
    logic [7:0]  data_sum;

    int errs    = 0;
    int checked = 0;
    int closed  = 0;

    function automatic logic [39:0] gcr_code_word(input logic [31:0] w);
        logic [39:0] bits;
        logic [3:0]  nib;
        bits = '0;
        for (int i = 0; i < 8; i++) begin
            nib  = w[31-4*i -: 4];
            bits = {bits[34:0], NIB_GCR[int'(nib)*5 +: 5]};
        end
        return bits;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        track_byte_t e;
        e.code      = b;
        e.run_end   = 1'b0;
        e.track_end = 1'b0;
        track_q.push_back(e);
    endtask

    task automatic put_group(input logic [31:0] w);
        logic [39:0] g;
        g = gcr_code_word(w);
        for (int i = 0; i < 5; i++) begin
            put_byte(g[39-8*i -: 8]);
        end
    endtask

    task automatic format_data_byte(input logic [7:0] d);
        int          start;
        logic [7:0]  hdr_sum;
        logic [31:0] word;
        logic        closing;
        track_byte_t tail;
        start   = track_q.size();
        closing = 1'b0;
        if (byte_pos == 8'd0) begin
            hdr_sum = {3'b0, sector} ^ {2'b0, trk_num} ^ id_a ^ id_b;
            repeat (SYNC_LENGTH_DEF) put_byte(SYNC_BYTE);
            put_group({HEADER_MARK, hdr_sum, 3'b0, sector, 2'b0, trk_num});
            // The id field carries the second id byte first.
            put_group({id_b, id_a, ID_PAD, ID_PAD});
            repeat (HEADER_GAP_DEF) put_byte(GAP_BYTE);
            repeat (SYNC_LENGTH_DEF) put_byte(SYNC_BYTE);
            held_bytes = {16'h0, DATA_MARK};
            data_sum   = 8'h00;
        end
        if (byte_pos == 8'd255) begin
            put_group({d, data_sum ^ d, 16'h0000});
            repeat ((gap_len > GAP_LIMIT) ? GAP_LIMIT : gap_len) put_byte(GAP_BYTE);
            // A sector total of zero behaves like one.
            closing    = ({1'b0, sector} + 6'd1) >= {1'b0, sec_total};
            sector     = closing ? 5'd0 : sector + 5'd1;
            held_bytes = '0;
            data_sum   = 8'h00;
            byte_pos   = 8'd0;
        end else begin
            word     = {held_bytes, d};
            data_sum = data_sum ^ d;
            if (byte_pos[1:0] == 2'd2) begin
                put_group(word);
                held_bytes = '0;
            end else begin
                held_bytes = word[23:0];
            end
            byte_pos = byte_pos + 8'd1;
        end
        if (track_q.size() > start) begin
            tail           = track_q.pop_back();
            tail.run_end   = 1'b1;
            tail.track_end = closing;
            track_q.push_back(tail);
        end
    endtask

    task automatic check_track_byte();
        track_byte_t want;
        if (track_q.size() == 0) begin
            if (errs < 10) begin
                $display("%0t: unexpected transfer: byte %h last %b done %b", $realtime,
                         m_gcr_byte, m_last_of_run, m_track_done);
            end
            errs++;
        end else begin
            want = track_q.pop_front();
            if (want.code !== m_gcr_byte || want.run_end !== m_last_of_run ||
                want.track_end !== m_track_done) begin
                if (errs < 10) begin
                    $display("%0t: track byte %0d: expected %h/%b/%b, got %h/%b/%b",
                             $realtime, checked, want.code, want.run_end, want.track_end,
                             m_gcr_byte, m_last_of_run, m_track_done);
                end
                errs++;
            end
        end
        checked++;
        if (m_track_done) begin
            closed++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            trk_num    = TRACK_RST;
            id_a       = ID_RST;
            id_b       = ID_RST;
            sec_total  = SECTORS_RST;
            gap_len    = GAP_RST;
            byte_pos   = 8'd0;
            sector     = 5'd0;
            held_bytes = '0;
            data_sum   = 8'h00;
            track_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_track_byte();
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_TRACK:   trk_num   = pwdata[5:0];
                    REG_ID_1ST:  id_a      = pwdata[7:0];
                    REG_ID_2ND:  id_b      = pwdata[7:0];
                    REG_SECTORS: sec_total = pwdata[4:0];
                    REG_GAP:     gap_len   = pwdata[5:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                format_data_byte(s_data_byte);
            end
        end
        error_count   <= errs;
        pending_count <= track_q.size();
        bytes_checked <= checked;
        tracks_closed <= closed;
    end

endmodule

FILE: sim/gcr_track_formatter_tb.sv
`timescale 1ns / 100ps
// Testbench top of the GCR track formatter: clock, reset, register setup and data
// byte stimulus with random idling on both channels; gives the verdict.
// Depends on gtf_pkg, gcr_track_formatter and gcr_track_formatter_chk.
module gcr_track_formatter_tb;
    import gtf_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int CORNER_COUNT  = 25;

    // Extremes, every nibble in both halves of a byte, and alternating patterns.
    localparam logic [8*CORNER_COUNT-1:0] CORNER_BYTES = {
        8'h00, 8'hFF, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF,
        8'hFE, 8'hDC, 8'hBA, 8'h98, 8'h76, 8'h54, 8'h32, 8'h10, 8'hAA, 8'h55,
        8'h0F, 8'hF0, 8'h80, 8'h7F, 8'h00
    };

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic [7:0]          s_data_byte = 8'h00;
    logic                m_ready     = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [31:0]         pwdata      = '0;

    logic                s_ready;
    logic                m_valid;
    logic [7:0]          m_gcr_byte;
    logic                m_last_of_run;
    logic                m_track_done;
    logic [31:0]         prdata;
    logic                pready;

    int error_count;
    int pending_count;
    int bytes_checked;
    int tracks_closed;

    int send_idle_pct = 9;
    int recv_idle_pct = 68;
    int cycles        = 0;
    int bytes_sent    = 0;
    int settings_used = 1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    gcr_track_formatter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_gcr_byte    (m_gcr_byte),
        .m_last_of_run (m_last_of_run),
        .m_track_done  (m_track_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    gcr_track_formatter_chk i_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_gcr_byte    (m_gcr_byte),
        .m_last_of_run (m_last_of_run),
        .m_track_done  (m_track_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .error_count   (error_count),
        .pending_count (pending_count),
        .bytes_checked (bytes_checked),
        .tracks_closed (tracks_closed)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every predicted track byte has arrived, then lets a byte that
    // produced nothing leave the front end before registers change.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers at their reset values; sector 0 opens with the corner bytes.
        for (int k = 0; k < CORNER_COUNT; k++) begin
            send_byte(CORNER_BYTES[8*(CORNER_COUNT-k)-1 -: 8]);
        end
        send_random(15);
        drain();

        // Track 42, one sector per track, longest gap.
        reg_write(REG_TRACK, 32'd42);
        reg_write(REG_ID_1ST, 32'hFF);
        reg_write(REG_ID_2ND, 32'h00);
        reg_write(REG_SECTORS, 32'd1);
        reg_write(REG_GAP, 32'd40);
        settings_used++;
        send_random(20);
        drain();

        send_idle_pct = 68;
        recv_idle_pct <= 9;

        // Out-of-range values: track cut to its six bits, zero sectors, oversized gap.
        reg_write(REG_TRACK, 32'hFFFF_FFFF);
        reg_write(REG_ID_1ST, 32'h00);
        reg_write(REG_ID_2ND, 32'hFF);
        reg_write(REG_SECTORS, 32'd0);
        reg_write(REG_GAP, 32'hFFFF_FFFF);
        settings_used++;
        send_random(20);
        drain();

        // Two sectors, no gap at first; then the gap and an id change mid-sector.
        reg_write(REG_TRACK, 32'd17);
        reg_write(REG_ID_1ST, $urandom);
        reg_write(REG_ID_2ND, $urandom);
        reg_write(REG_SECTORS, 32'd2);
        reg_write(REG_GAP, 32'd0);
        settings_used++;
        send_random(10);
        drain();
        reg_write(REG_GAP, 32'd21);
        reg_write(REG_ID_1ST, $urandom);
        settings_used++;
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        send_random(10);
        drain();

        $display("Sent %0d data bytes under %0d register settings; checked %0d track bytes,",
                 bytes_sent, settings_used, bytes_checked);
        $display("of which %0d closed a track.", tracks_closed);
        if (error_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
